>>> hdl/swq_pkg.sv
// Shared constants, types and command/status structs for the sliding window quantile block.
`default_nettype none

package swq_pkg;

    localparam int SAMPLE_BITS    = 32;
    localparam int FRAC_BITS      = 17;
    localparam int FRAC_SHIFT     = 16;
    localparam int FRAC_ONE       = 65536;
    localparam int FRAC_HALF      = 32768;
    localparam int WINDOW_BITS    = 7;
    localparam int COUNT_BITS     = 7;
    localparam int MAX_WINDOW_DEF = 64;
    localparam int WINDOW_RESET   = 60;

    localparam int IN_DATA_BITS   = 56;
    localparam int OUT_DATA_BITS  = 40;
    localparam int ADDR_BITS      = 3;

    // Command codes carried on the input tuser bit.
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_WINDOW = 1'b0;

    typedef struct packed {
        logic load;      // capture the input beat
        logic evict;     // remove the oldest sample
        logic insert;    // put the captured sample into its sorted place
        logic rank;      // multiply out the rank position
        logic index;     // round and clamp the rank into a cell index
        logic group;     // first stage of the cell read
        logic emit;      // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic push;      // captured beat is a push
        logic full;      // store holds a whole window
        logic out_busy;  // output register holds a beat that is not taken this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hdl/swq_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`default_nettype none

module swq_ctrl
    import swq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_EVICT,
        ST_INSERT,
        ST_RANK,
        ST_INDEX,
        ST_GROUP,
        ST_OUTPUT
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;
    logic   accept;

    assign accept     = i_s_tvalid & r_ready;
    assign o_s_tready = r_ready;

    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_ready    = 1'b0;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                if (!i_stat.push) begin
                    n_state = ST_RANK;
                end else if (i_stat.full) begin
                    n_state = ST_EVICT;
                end else begin
                    n_state = ST_INSERT;
                end
            end
            ST_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = ST_INSERT;
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = ST_RANK;
            end
            ST_RANK: begin
                o_cmd.rank = 1'b1;
                n_state    = ST_INDEX;
            end
            ST_INDEX: begin
                o_cmd.index = 1'b1;
                n_state     = ST_GROUP;
            end
            ST_GROUP: begin
                o_cmd.group = 1'b1;
                n_state     = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                // Hold here until the output register can take the beat.
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_ready    = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

endmodule

`default_nettype wire

>>> hdl/swq_dp.sv
// Datapath: sorted sample cells with ages, rank arithmetic, cell read and output register.
`default_nettype none

module swq_dp
    import swq_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  wire logic [WINDOW_BITS-1:0]        i_window,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_stat                           o_stat,
    input  wire logic                          i_command,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [FRAC_BITS-1:0]          i_rank_fraction,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_quantile_value,
    output logic                               o_is_empty,
    output logic [COUNT_BITS-1:0]              o_sample_count
);

    localparam int CW      = $clog2(MAX_WINDOW + 1);
    localparam int IW      = $clog2(MAX_WINDOW);
    localparam int AGE_MOD = 2 * MAX_WINDOW;
    localparam int AW      = $clog2(AGE_MOD);
    localparam int PW      = CW + FRAC_BITS + 1;
    localparam int GS      = 8;
    localparam int NG      = (MAX_WINDOW + GS - 1) / GS;

    logic signed [SAMPLE_BITS-1:0] r_val [MAX_WINDOW];
    logic        [AW-1:0]          r_age [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] n_val [MAX_WINDOW];
    logic        [AW-1:0]          n_age [MAX_WINDOW];

    logic [CW-1:0]                 r_held;
    logic [AW-1:0]                 r_arrival;
    logic                          r_command;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [FRAC_BITS-1:0]          r_frac;
    logic [PW-1:0]                 r_prod;
    logic [IW-1:0]                 r_idx;
    logic signed [SAMPLE_BITS-1:0] r_grp [NG];

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_empty;
    logic [COUNT_BITS-1:0]         r_out_count;

    logic [CW-1:0]                 live;
    logic [AW-1:0]                 oldest;
    logic [MAX_WINDOW-1:0]         past;
    logic [MAX_WINDOW-1:0]         ins;
    logic [PW-1:0]                 n_prod;
    logic [PW-1:0]                 quot;
    logic [IW-1:0]                 n_idx;
    logic signed [SAMPLE_BITS-1:0] n_grp [NG];
    logic signed [SAMPLE_BITS-1:0] pick;

    // A zero window acts as one sample, a window beyond the cell count saturates.
    always_comb begin
        if (i_window == '0) begin
            live = CW'(1);
        end else if (int'(i_window) > MAX_WINDOW) begin
            live = CW'(MAX_WINDOW);
        end else begin
            live = CW'(i_window);
        end
    end

    // Arrivals since the last clear are consecutive, so the oldest held sample
    // carries the arrival number that lies held_count behind the next one.
    always_comb begin
        if (int'(r_arrival) >= int'(r_held)) begin
            oldest = AW'(int'(r_arrival) - int'(r_held));
        end else begin
            oldest = AW'(int'(r_arrival) + AGE_MOD - int'(r_held));
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            past[i] = (CW'(i) < r_held) && (r_age[i] == oldest);
            if (i > 0) begin
                past[i] = past[i] | past[i-1];
            end
            // Cells from the insert position up to the first free cell take part.
            ins[i] = (CW'(i) < r_held) ? (r_val[i] > r_sample) : (CW'(i) == r_held);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            n_val[i] = r_val[i];
            n_age[i] = r_age[i];
            if (i_cmd.evict) begin
                if (past[i] && (i + 1 < MAX_WINDOW)) begin
                    n_val[i] = r_val[(i + 1) % MAX_WINDOW];
                    n_age[i] = r_age[(i + 1) % MAX_WINDOW];
                end
            end else if (i_cmd.insert) begin
                if (ins[i]) begin
                    if ((i > 0) && ins[(i + MAX_WINDOW - 1) % MAX_WINDOW]) begin
                        n_val[i] = r_val[(i + MAX_WINDOW - 1) % MAX_WINDOW];
                        n_age[i] = r_age[(i + MAX_WINDOW - 1) % MAX_WINDOW];
                    end else begin
                        n_val[i] = r_sample;
                        n_age[i] = r_arrival;
                    end
                end
            end
        end
    end

    assign n_prod = PW'(r_held - CW'(1)) * PW'(r_frac) + PW'(FRAC_HALF);
    assign quot   = r_prod >> FRAC_SHIFT;

    always_comb begin
        if (quot >= PW'(r_held)) begin
            n_idx = IW'(r_held - CW'(1));
        end else begin
            n_idx = IW'(quot);
        end
    end

    // The cell read goes in two registered steps: a cell within each group of
    // eight, then the group.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GS; k++) begin
                if ((g * GS + k < MAX_WINDOW) && ((int'(r_idx) % GS) == k)) begin
                    n_grp[g] = r_val[(g * GS + k) % MAX_WINDOW];
                end
            end
        end
        pick = '0;
        for (int g = 0; g < NG; g++) begin
            if ((int'(r_idx) / GS) == g) begin
                pick = r_grp[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            r_val[i] <= n_val[i];
            r_age[i] <= n_age[i];
        end
        for (int g = 0; g < NG; g++) begin
            if (i_cmd.group) begin
                r_grp[g] <= n_grp[g];
            end
        end
        if (i_cmd.load) begin
            r_command <= i_command;
            r_sample  <= i_sample;
            r_frac    <= (int'(i_rank_fraction) > FRAC_ONE) ? FRAC_BITS'(FRAC_ONE)
                                                             : i_rank_fraction;
        end
        if (i_cmd.rank) begin
            r_prod <= n_prod;
        end
        if (i_cmd.index) begin
            r_idx <= n_idx;
        end
        if (i_cmd.emit) begin
            r_out_value <= (r_held == '0) ? '0 : pick;
            r_out_empty <= (r_held == '0);
            r_out_count <= COUNT_BITS'(r_held);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_arrival   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_held    <= '0;
                r_arrival <= '0;
            end else if (i_cmd.evict) begin
                r_held <= r_held - CW'(1);
            end else if (i_cmd.insert) begin
                r_held    <= r_held + CW'(1);
                r_arrival <= (int'(r_arrival) == AGE_MOD - 1) ? '0 : r_arrival + AW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.push     = (r_command == CMD_PUSH);
    assign o_stat.full     = (r_held >= live);
    assign o_stat.out_busy = r_out_valid & ~i_ready;

    assign o_valid          = r_out_valid;
    assign o_quantile_value = r_out_value;
    assign o_is_empty       = r_out_empty;
    assign o_sample_count   = r_out_count;

endmodule

`default_nettype wire

>>> hdl/sliding_window_quantile.sv
// Top level of the sliding window quantile block: configuration port, controller and datapath.
//
//   Channel   Direction  Beat fields (lowest bits first)
//   s stream  in         tdata: sample[31:0], rank_fraction[48:32]; tuser: command
//   m stream  out        tdata: quantile_value[31:0], sample_count[38:32]; tuser: is_empty
//   APB       in/out     window_size at byte address 0
//
// One item runs from accept to result through a decision state, then the controller walks
// evict (only on a push into a full window), insert (on a push only), rank multiply,
// rounding and a two-step cell read.
// The next item is accepted in the cycle after the result enters the output register,
// so items do not overlap: a new item is not taken before the last one is through.
// A stalled output holds its beat; the controller then waits before loading the next one.
// Reset is synchronous: the store is empty and the window is 60.
`default_nettype none

module sliding_window_quantile
    import swq_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    input  wire logic [IN_DATA_BITS-1:0]  i_s_tdata,   // sample, rank_fraction, zero pad
    input  wire logic                     i_s_tuser,   // command
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0]      o_m_tdata,   // quantile_value, sample_count, zero pad
    output logic                          o_m_tuser,   // is_empty
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_BITS-1:0]     paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [WINDOW_BITS-1:0]        r_window;
    logic                          cfg_write;
    t_dp_cmd                       cmd;
    t_dp_stat                      stat;
    logic signed [SAMPLE_BITS-1:0] quantile_value;
    logic [COUNT_BITS-1:0]         sample_count;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_WINDOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_BITS'(WINDOW_RESET);
        end else if (cfg_write) begin
            r_window <= pwdata[WINDOW_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_WINDOW) ? {{(32 - WINDOW_BITS){1'b0}}, r_window} : '0;

    swq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    swq_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_clear          (cfg_write),
        .i_window         (r_window),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_command        (i_s_tuser),
        .i_sample         (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_rank_fraction  (i_s_tdata[SAMPLE_BITS +: FRAC_BITS]),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_quantile_value (quantile_value),
        .o_is_empty       (o_m_tuser),
        .o_sample_count   (sample_count)
    );

    assign o_m_tdata = {{(OUT_DATA_BITS - SAMPLE_BITS - COUNT_BITS){1'b0}},
                        sample_count, quantile_value};

endmodule

`default_nettype wire
